>>> sv/y2r_pkg.sv
// ----------------------------------------------------------------------------
// y2r_pkg: shared types and codes for the YUYV to RGB888 stream converter
// Holds the byte phase codes and the pair record passed from the front end
// through the queue to the colour back end.
// ----------------------------------------------------------------------------
package y2r_pkg;

    // Byte phase within one Y0 U Y1 V group (one-hot)
    typedef enum logic [3:0] {
        PH_Y0 = 4'b0001,
        PH_U  = 4'b0010,
        PH_Y1 = 4'b0100,
        PH_V  = 4'b1000
    } phase_t;

    // Configuration register indexes
    localparam logic REG_PPL = 1'b0;
    localparam logic REG_LPF = 1'b1;

    // Register widths and reset values
    localparam int unsigned CFG_W     = 12;
    localparam int unsigned CNT_W     = 11;
    localparam logic [CFG_W-1:0] PPL_RESET = 12'd320;
    localparam logic [CFG_W-1:0] LPF_RESET = 12'd480;
    localparam logic [CNT_W-1:0] CNT_MAX   = 11'd2047;

    // One complete pixel pair, ready for colour conversion
    typedef struct packed {
        logic [7:0]       y_first;
        logic [7:0]       u;
        logic [7:0]       y_second;
        logic [7:0]       v;
        logic [CNT_W-1:0] column;
        logic [CNT_W-1:0] line;
        logic             frame_end;
    } pair_t;

endpackage

>>> sv/yuyv_to_rgb888_stream_core.sv
// ----------------------------------------------------------------------------
// yuyv_to_rgb888_stream_core: YUYV 4:2:2 byte stream to RGB888 pixel pairs
// Front end sequences Y0 U Y1 V bytes and tracks frame position, a short
// queue decouples it from the two-stage full-range BT.601 colour back end.
//
// Channel  Direction  Handshake           Payload
// in       sink       in_valid/in_stall   action, data_byte
// out      source     out_valid/out_stall RGB of both pixels, pair_column,
//                                         line_number, frame_end
// cfg      sink       cfg_we              cfg_index, cfg_data
//
// One byte is taken per cycle while in_stall is low; a pair passes through the
// queue write, the product stage and the output register after its V byte.
// in_stall rises only when the pair queue is full, so a stalled output backs
// up through the queue before the byte side is held.
// Reset clears phase, held bytes, counters, queue and pipeline valids and
// loads the line and frame limits with 320 and 480.
// ----------------------------------------------------------------------------
module yuyv_to_rgb888_stream_core #(
    parameter int unsigned COEF_FRAC_BITS = 16,
    parameter int unsigned QUEUE_DEPTH    = 4
) (
    input  logic        clk,
    input  logic        rst_n,
    // configuration
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [11:0] cfg_data,
    // byte input
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        action,
    input  logic [7:0]  data_byte,
    // pair output
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  red_first,
    output logic [7:0]  green_first,
    output logic [7:0]  blue_first,
    output logic [7:0]  red_second,
    output logic [7:0]  green_second,
    output logic [7:0]  blue_second,
    output logic [10:0] pair_column,
    output logic [10:0] line_number,
    output logic        frame_end
);

    logic           in_take;
    logic           push;
    y2r_pkg::pair_t push_pair;
    logic           q_full;
    logic           q_not_empty;
    logic           q_pop;
    y2r_pkg::pair_t q_head;

    // Input transfer
    assign in_stall = q_full;
    assign in_take  = in_valid && !in_stall;

    y2r_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_take   (in_take),
        .action    (action),
        .data_byte (data_byte),
        .push      (push),
        .push_pair (push_pair)
    );

    y2r_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_pair (push_pair),
        .pop       (q_pop),
        .full      (q_full),
        .not_empty (q_not_empty),
        .head      (q_head)
    );

    y2r_back #(
        .COEF_FRAC_BITS (COEF_FRAC_BITS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_not_empty  (q_not_empty),
        .q_head       (q_head),
        .q_pop        (q_pop),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .red_first    (red_first),
        .green_first  (green_first),
        .blue_first   (blue_first),
        .red_second   (red_second),
        .green_second (green_second),
        .blue_second  (blue_second),
        .pair_column  (pair_column),
        .line_number  (line_number),
        .frame_end    (frame_end)
    );

endmodule

>>> sv/y2r_front.sv
// ----------------------------------------------------------------------------
// y2r_front: byte sequencer and frame position counters
// Takes one byte per transfer, holds Y0, U and Y1, and on the V byte builds a
// pair record with its column, line and end-of-frame flag.
// ----------------------------------------------------------------------------
module y2r_front (
    input  logic                      clk,
    input  logic                      rst_n,
    // configuration
    input  logic                      cfg_we,
    input  logic                      cfg_index,
    input  logic [y2r_pkg::CFG_W-1:0] cfg_data,
    // accepted input transfer
    input  logic                      in_take,
    input  logic                      action,
    input  logic [7:0]                data_byte,
    // pair towards the queue
    output logic                      push,
    output y2r_pkg::pair_t            push_pair
);

    y2r_pkg::phase_t              phase_reg, phase_next;
    logic [7:0]                   y_first_reg, y_first_next;
    logic [7:0]                   u_reg, u_next;
    logic [7:0]                   y_second_reg, y_second_next;
    logic [y2r_pkg::CNT_W-1:0]    col_reg, col_next;
    logic [y2r_pkg::CNT_W-1:0]    line_reg, line_next;
    logic [y2r_pkg::CFG_W-1:0]    ppl_reg, lpf_reg;
    logic                         last_col, last_line;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ppl_reg <= y2r_pkg::PPL_RESET;
            lpf_reg <= y2r_pkg::LPF_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                y2r_pkg::REG_PPL: ppl_reg <= cfg_data;
                y2r_pkg::REG_LPF: lpf_reg <= cfg_data;
                default:          ppl_reg <= ppl_reg;
            endcase
        end
    end

    // End of line / frame; zero limits act as one, counter wraps after 2047
    assign last_col  = (({1'b0, col_reg} + 12'd1) >= ppl_reg)
                       || (col_reg == y2r_pkg::CNT_MAX);
    assign last_line = (({1'b0, line_reg} + 12'd1) >= lpf_reg)
                       || (line_reg == y2r_pkg::CNT_MAX);

    // Pair record, valid on the V byte
    assign push = in_take && !action && (phase_reg == y2r_pkg::PH_V);
    always_comb
    begin
        push_pair.y_first   = y_first_reg;
        push_pair.u         = u_reg;
        push_pair.y_second  = y_second_reg;
        push_pair.v         = data_byte;
        push_pair.column    = col_reg;
        push_pair.line      = line_reg;
        push_pair.frame_end = last_col && last_line;
    end

    // Phase, held bytes and counters
    always_comb
    begin
        phase_next    = phase_reg;
        y_first_next  = y_first_reg;
        u_next        = u_reg;
        y_second_next = y_second_reg;
        col_next      = col_reg;
        line_next     = line_reg;
        if (in_take)
        begin
            if (action)
            begin
                phase_next    = y2r_pkg::PH_Y0;
                y_first_next  = 8'd0;
                u_next        = 8'd0;
                y_second_next = 8'd0;
                col_next      = '0;
                line_next     = '0;
            end
            else
            begin
                unique case (phase_reg)
                    y2r_pkg::PH_Y0:
                    begin
                        y_first_next = data_byte;
                        phase_next   = y2r_pkg::PH_U;
                    end
                    y2r_pkg::PH_U:
                    begin
                        u_next     = data_byte;
                        phase_next = y2r_pkg::PH_Y1;
                    end
                    y2r_pkg::PH_Y1:
                    begin
                        y_second_next = data_byte;
                        phase_next    = y2r_pkg::PH_V;
                    end
                    y2r_pkg::PH_V:
                    begin
                        phase_next = y2r_pkg::PH_Y0;
                        if (last_col)
                        begin
                            col_next  = '0;
                            line_next = last_line ? '0 : line_reg + 11'd1;
                        end
                        else
                        begin
                            col_next = col_reg + 11'd1;
                        end
                    end
                    default:
                    begin
                        phase_next = y2r_pkg::PH_Y0;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= y2r_pkg::PH_Y0;
            y_first_reg  <= 8'd0;
            u_reg        <= 8'd0;
            y_second_reg <= 8'd0;
            col_reg      <= '0;
            line_reg     <= '0;
        end
        else
        begin
            phase_reg    <= phase_next;
            y_first_reg  <= y_first_next;
            u_reg        <= u_next;
            y_second_reg <= y_second_next;
            col_reg      <= col_next;
            line_reg     <= line_next;
        end
    end

    // Restart clears position and phase
    a_restart_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (in_take && action) |=>
            (phase_reg == y2r_pkg::PH_Y0) && (col_reg == '0) && (line_reg == '0))
        else $error("restart did not clear phase and counters");

    // Frame end wraps both counters back to zero
    a_frame_end_pos: assert property (@(posedge clk) disable iff (!rst_n)
        (push && push_pair.frame_end) |=> (col_reg == '0) && (line_reg == '0))
        else $error("counters not wrapped after end of frame");

endmodule

>>> sv/y2r_queue.sv
// ----------------------------------------------------------------------------
// y2r_queue: short pair queue between front end and back end
// Register-based circular buffer; the front end stalls on full.
// ----------------------------------------------------------------------------
module y2r_queue #(
    parameter int unsigned DEPTH = 4
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  y2r_pkg::pair_t push_pair,
    input  logic           pop,
    output logic           full,
    output logic           not_empty,
    output y2r_pkg::pair_t head
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    y2r_pkg::pair_t      slot_reg [DEPTH];
    logic [PTR_W-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]    count_reg, count_next;

    assign full      = (count_reg == FULL_CNT);
    assign not_empty = (count_reg != '0);
    assign head      = slot_reg[rd_ptr_reg];

    // Pointer and fill bookkeeping
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_pair;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && full))
        else $error("push into full queue");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(pop && !not_empty))
        else $error("pop from empty queue");

endmodule

>>> sv/y2r_back.sv
// ----------------------------------------------------------------------------
// y2r_back: BT.601 full-range colour conversion, two pipeline stages
// Stage one forms the four chroma products; stage two adds luma, floors,
// clips and holds the result in the output register.
// ----------------------------------------------------------------------------
module y2r_back #(
    parameter int unsigned COEF_FRAC_BITS = 16
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           q_not_empty,
    input  y2r_pkg::pair_t q_head,
    output logic           q_pop,
    output logic           out_valid,
    input  logic           out_stall,
    output logic [7:0]     red_first,
    output logic [7:0]     green_first,
    output logic [7:0]     blue_first,
    output logic [7:0]     red_second,
    output logic [7:0]     green_second,
    output logic [7:0]     blue_second,
    output logic [10:0]    pair_column,
    output logic [10:0]    line_number,
    output logic           frame_end
);

    localparam int unsigned F  = COEF_FRAC_BITS;
    localparam int unsigned CW = F + 2;    // signed coefficient width
    localparam int unsigned PW = CW + 9;   // product width
    localparam int unsigned SW = PW + 2;   // sum width

    // round(c * 2^F) for c = 1.402, 0.344136, 0.714136, 1.772
    localparam longint unsigned KR_L  = ((64'd1402000 << F) + 64'd500000) / 64'd1000000;
    localparam longint unsigned KGU_L = ((64'd344136 << F) + 64'd500000) / 64'd1000000;
    localparam longint unsigned KGV_L = ((64'd714136 << F) + 64'd500000) / 64'd1000000;
    localparam longint unsigned KB_L  = ((64'd1772000 << F) + 64'd500000) / 64'd1000000;
    localparam logic signed [CW-1:0] KR  = CW'(KR_L);
    localparam logic signed [CW-1:0] KGU = CW'(KGU_L);
    localparam logic signed [CW-1:0] KGV = CW'(KGV_L);
    localparam logic signed [CW-1:0] KB  = CW'(KB_L);

    // Floor the fixed-point sum to an integer and clip to 0..255
    function automatic logic [7:0] floor_clip(input logic signed [SW-1:0] s);
        logic signed [SW-1:0] t;
        t = s >>> F;
        if (t[SW-1])
            return 8'd0;
        else if (|t[SW-2:8])
            return 8'd255;
        else
            return t[7:0];
    endfunction

    // Sign-extend a product to the sum width
    function automatic logic signed [SW-1:0] ext(input logic signed [PW-1:0] p);
        return {{(SW-PW){p[PW-1]}}, p};
    endfunction

    // Luma scaled to the sum width
    function automatic logic signed [SW-1:0] luma(input logic [7:0] y);
        return {{(SW-8-F){1'b0}}, y, {F{1'b0}}};
    endfunction

    logic                     s1_valid_reg;
    logic signed [PW-1:0]     pr_reg, pgu_reg, pgv_reg, pb_reg;
    logic [7:0]               y_first_reg, y_second_reg;
    logic [10:0]              s1_col_reg, s1_line_reg;
    logic                     s1_end_reg;
    logic                     out_valid_reg;
    logic                     out_adv, s1_adv;
    logic signed [8:0]        du, dv;
    logic [7:0]               r0_next, g0_next, b0_next, r1_next, g1_next, b1_next;
    logic [7:0]               r0_reg, g0_reg, b0_reg, r1_reg, g1_reg, b1_reg;
    logic [10:0]              col_reg, line_reg;
    logic                     end_reg;

    // Stage handshakes
    assign out_adv = !out_valid_reg || !out_stall;
    assign s1_adv  = !s1_valid_reg || out_adv;
    assign q_pop   = q_not_empty && s1_adv;

    // Stage one: chroma offsets and products
    assign du = $signed({1'b0, q_head.u}) - 9'sd128;
    assign dv = $signed({1'b0, q_head.v}) - 9'sd128;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (s1_adv)
        begin
            s1_valid_reg <= q_not_empty;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            pr_reg       <= KR * dv;
            pgu_reg      <= KGU * du;
            pgv_reg      <= KGV * dv;
            pb_reg       <= KB * du;
            y_first_reg  <= q_head.y_first;
            y_second_reg <= q_head.y_second;
            s1_col_reg   <= q_head.column;
            s1_line_reg  <= q_head.line;
            s1_end_reg   <= q_head.frame_end;
        end
    end

    // Stage two: add luma, floor and clip
    always_comb
    begin
        r0_next = floor_clip(luma(y_first_reg) + ext(pr_reg));
        g0_next = floor_clip(luma(y_first_reg) - ext(pgu_reg) - ext(pgv_reg));
        b0_next = floor_clip(luma(y_first_reg) + ext(pb_reg));
        r1_next = floor_clip(luma(y_second_reg) + ext(pr_reg));
        g1_next = floor_clip(luma(y_second_reg) - ext(pgu_reg) - ext(pgv_reg));
        b1_next = floor_clip(luma(y_second_reg) + ext(pb_reg));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_adv)
        begin
            out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_adv && s1_valid_reg)
        begin
            r0_reg   <= r0_next;
            g0_reg   <= g0_next;
            b0_reg   <= b0_next;
            r1_reg   <= r1_next;
            g1_reg   <= g1_next;
            b1_reg   <= b1_next;
            col_reg  <= s1_col_reg;
            line_reg <= s1_line_reg;
            end_reg  <= s1_end_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign red_first    = r0_reg;
    assign green_first  = g0_reg;
    assign blue_first   = b0_reg;
    assign red_second   = r1_reg;
    assign green_second = g1_reg;
    assign blue_second  = b1_reg;
    assign pair_column  = col_reg;
    assign line_number  = line_reg;
    assign frame_end    = end_reg;

    // A held stage-one pair is not lost while the output is stalled
    a_s1_held: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !out_adv) |=> s1_valid_reg)
        else $error("stage one dropped a pair under stall");

    // Nothing is popped while stage one cannot move
    a_pop_only_free: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> s1_adv)
        else $error("pop while stage one blocked");

endmodule

>>> sim/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the YUYV to RGB888 stream converter
// Drives a byte stream of Y0 U Y1 V groups, restarts and stray bytes with
// random gaps on both channels. A behavioural converter inside the bench
// predicts every pixel pair. Each pair that leaves the block is compared
// field by field with the oldest expectation. A short directed table comes
// first, then random phases under several line and frame limits, including
// zero, a wide line and a limit lowered part way through a frame.
// ----------------------------------------------------------------------------
module tb;

    localparam int     FRAC      = 16;
    localparam int     LONG_HOLD = 400;
    localparam longint K_R  = ((longint'(1402000) << FRAC) + 500000) / 1000000;
    localparam longint K_GU = ((longint'(344136) << FRAC) + 500000) / 1000000;
    localparam longint K_GV = ((longint'(714136) << FRAC) + 500000) / 1000000;
    localparam longint K_B  = ((longint'(1772000) << FRAC) + 500000) / 1000000;

    typedef struct packed {
        logic [7:0]  red_first;
        logic [7:0]  green_first;
        logic [7:0]  blue_first;
        logic [7:0]  red_second;
        logic [7:0]  green_second;
        logic [7:0]  blue_second;
        logic [10:0] pair_column;
        logic [10:0] line_number;
        logic        frame_end;
    } pixel_pair_t;

    // One byte of the directed table; a fixed expectation rides on V rows only
    typedef struct packed {
        logic        act;
        logic [7:0]  b;
        logic        typed;
        pixel_pair_t want;
    } dir_row_t;

    localparam pixel_pair_t NONE  = '0;
    localparam pixel_pair_t BW_00 = '{8'd0, 8'd0, 8'd0, 8'd255, 8'd255, 8'd255,
                                      11'd0, 11'd0, 1'b0};
    localparam pixel_pair_t GREY1 = '{8'd128, 8'd128, 8'd128, 8'd128, 8'd128,
                                      8'd128, 11'd1, 11'd0, 1'b0};
    localparam pixel_pair_t WH_00 = '{8'd255, 8'd255, 8'd255, 8'd255, 8'd255,
                                      8'd255, 11'd0, 11'd0, 1'b0};

    localparam int DIR_LEN = 24;
    localparam dir_row_t DIRECTED [DIR_LEN] = '{
        // black and white at neutral chroma
        '{1'b0, 8'd0,   1'b0, NONE},
        '{1'b0, 8'd128, 1'b0, NONE},
        '{1'b0, 8'd255, 1'b0, NONE},
        '{1'b0, 8'd128, 1'b1, BW_00},
        // mid grey
        '{1'b0, 8'd128, 1'b0, NONE},
        '{1'b0, 8'd128, 1'b0, NONE},
        '{1'b0, 8'd128, 1'b0, NONE},
        '{1'b0, 8'd128, 1'b1, GREY1},
        // full chroma both ways, clipping high and low
        '{1'b0, 8'd255, 1'b0, NONE},
        '{1'b0, 8'd255, 1'b0, NONE},
        '{1'b0, 8'd0,   1'b0, NONE},
        '{1'b0, 8'd255, 1'b0, NONE},
        '{1'b0, 8'd0,   1'b0, NONE},
        '{1'b0, 8'd0,   1'b0, NONE},
        '{1'b0, 8'd255, 1'b0, NONE},
        '{1'b0, 8'd0,   1'b0, NONE},
        // partial group dropped by a restart
        '{1'b0, 8'd77,  1'b0, NONE},
        '{1'b0, 8'd200, 1'b0, NONE},
        '{1'b1, 8'hA5,  1'b0, NONE},
        // white, back at the frame origin
        '{1'b0, 8'd255, 1'b0, NONE},
        '{1'b0, 8'd128, 1'b0, NONE},
        '{1'b0, 8'd255, 1'b0, NONE},
        '{1'b0, 8'd128, 1'b1, WH_00},
        '{1'b1, 8'hFF,  1'b0, NONE}
    };

    logic        clk = 1'b0;
    logic        rst_n;
    logic        cfg_we;
    logic        cfg_index;
    logic [11:0] cfg_data;
    logic        in_valid;
    logic        in_stall;
    logic        action;
    logic [7:0]  data_byte;
    logic        out_valid;
    logic        out_stall;
    logic [7:0]  red_first;
    logic [7:0]  green_first;
    logic [7:0]  blue_first;
    logic [7:0]  red_second;
    logic [7:0]  green_second;
    logic [7:0]  blue_second;
    logic [10:0] pair_column;
    logic [10:0] line_number;
    logic        frame_end;

    // fixed expectation travelling with the byte on offer
    logic        typed_on;
    pixel_pair_t typed_pair;

    // predicted converter state
    y2r_pkg::phase_t            ph;
    logic [7:0]                 hy0;
    logic [7:0]                 hu;
    logic [7:0]                 hy1;
    logic [y2r_pkg::CNT_W-1:0]  col_cnt;
    logic [y2r_pkg::CNT_W-1:0]  line_cnt;
    logic [y2r_pkg::CFG_W-1:0]  ppl_reg;
    logic [y2r_pkg::CFG_W-1:0]  lpf_reg;

    pixel_pair_t pairs_due[$];
    int          errors = 0;
    bit          steady = 1'b0;
    bit          hold_req = 1'b0;

    yuyv_to_rgb888_stream_core #(.COEF_FRAC_BITS(FRAC)) dut (.*);

    always #2 clk = ~clk;

    // ------------------------------------------------------------------
    // prediction
    // ------------------------------------------------------------------
    function automatic logic [7:0] clip_q(input longint q);
        longint v;
        v = q >>> FRAC;
        if (v < 0)
            return 8'd0;
        if (v > 255)
            return 8'd255;
        return v[7:0];
    endfunction

    function automatic logic [23:0] to_rgb(input logic [7:0] y, input longint du,
                                           input longint dv);
        longint base;
        base = longint'(y) << FRAC;
        return {clip_q(base + K_R * dv), clip_q(base - K_GU * du - K_GV * dv),
                clip_q(base + K_B * du)};
    endfunction

    task automatic advance_converter(input logic act, input logic [7:0] b,
                                     output logic made, output pixel_pair_t res);
        longint du;
        longint dv;
        logic   end_col;
        logic   end_line;
        made = 1'b0;
        res  = '0;
        if (act) begin
            ph       = y2r_pkg::PH_Y0;
            hy0      = '0;
            hu       = '0;
            hy1      = '0;
            col_cnt  = '0;
            line_cnt = '0;
        end
        else begin
            case (ph)
                y2r_pkg::PH_Y0:
                begin
                    hy0 = b;
                    ph  = y2r_pkg::PH_U;
                end
                y2r_pkg::PH_U:
                begin
                    hu = b;
                    ph = y2r_pkg::PH_Y1;
                end
                y2r_pkg::PH_Y1:
                begin
                    hy1 = b;
                    ph  = y2r_pkg::PH_V;
                end
                default:
                begin
                    ph = y2r_pkg::PH_Y0;
                    du = longint'(hu) - 128;
                    dv = longint'(b) - 128;
                    {res.red_first, res.green_first, res.blue_first} = to_rgb(hy0, du, dv);
                    {res.red_second, res.green_second, res.blue_second} =
                        to_rgb(hy1, du, dv);
                    // a limit of zero acts as one; the counter caps the rest
                    end_col  = (int'(col_cnt) + 1 >= int'(ppl_reg))
                               || (col_cnt >= y2r_pkg::CNT_MAX);
                    end_line = (int'(line_cnt) + 1 >= int'(lpf_reg))
                               || (line_cnt >= y2r_pkg::CNT_MAX);
                    res.pair_column = col_cnt;
                    res.line_number = line_cnt;
                    res.frame_end   = end_col && end_line;
                    if (end_col) begin
                        col_cnt  = '0;
                        line_cnt = end_line ? '0 : line_cnt + 1'b1;
                    end
                    else
                        col_cnt = col_cnt + 1'b1;
                    made = 1'b1;
                end
            endcase
        end
    endtask

    // register writes and byte transfers, sampled before the edge settles
    always @(posedge clk) begin : model_update
        pixel_pair_t nxt;
        logic        made;
        if (rst_n) begin
            if (cfg_we) begin
                if (cfg_index == y2r_pkg::REG_PPL)
                    ppl_reg = cfg_data;
                else
                    lpf_reg = cfg_data;
            end
            if (in_valid && !in_stall) begin
                advance_converter(action, data_byte, made, nxt);
                if (made)
                    pairs_due.push_back(typed_on ? typed_pair : nxt);
            end
        end
    end

    // ------------------------------------------------------------------
    // checking
    // ------------------------------------------------------------------
    task automatic flag_mismatch(input string what, input int got, input int want);
        errors++;
        if (errors <= 60)
            $display("%0t ns  %s: got %0d, want %0d", $time, what, got, want);
    endtask

    always @(posedge clk) begin : pair_check
        pixel_pair_t want;
        if (rst_n && out_valid && !out_stall) begin
            if (pairs_due.size() == 0)
                flag_mismatch("pair with none due, column", pair_column, -1);
            else begin
                want = pairs_due.pop_front();
                if (red_first !== want.red_first)
                    flag_mismatch("red_first", red_first, want.red_first);
                if (green_first !== want.green_first)
                    flag_mismatch("green_first", green_first, want.green_first);
                if (blue_first !== want.blue_first)
                    flag_mismatch("blue_first", blue_first, want.blue_first);
                if (red_second !== want.red_second)
                    flag_mismatch("red_second", red_second, want.red_second);
                if (green_second !== want.green_second)
                    flag_mismatch("green_second", green_second, want.green_second);
                if (blue_second !== want.blue_second)
                    flag_mismatch("blue_second", blue_second, want.blue_second);
                if (pair_column !== want.pair_column)
                    flag_mismatch("pair_column", pair_column, want.pair_column);
                if (line_number !== want.line_number)
                    flag_mismatch("line_number", line_number, want.line_number);
                if (frame_end !== want.frame_end)
                    flag_mismatch("frame_end", frame_end, want.frame_end);
            end
        end
    end

    // ------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------
    // mostly back to back, some short gaps, the odd long one
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [7:0] pick_byte();
        int r;
        r = $urandom_range(0, 99);
        if (r < 15)
            return 8'd0;
        if (r < 30)
            return 8'd255;
        if (r < 40)
            return 8'd128;
        return 8'($urandom_range(0, 255));
    endfunction

    // offer one byte and hold it until the transfer
    task automatic push_byte(input logic act, input logic [7:0] b, input logic typed,
                             input pixel_pair_t want);
        int gap;
        gap = steady ? 0 : idle_len();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid   <= 1'b1;
        action     <= act;
        data_byte  <= b;
        typed_on   <= typed;
        typed_pair <= want;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    // well-formed groups with random content, some stray bytes and restarts
    task automatic run_random(input int n, input bit restarts);
        int sent;
        int r;
        int k;
        sent = 0;
        while (sent < n) begin
            r = $urandom_range(0, 99);
            if (restarts && r < 4) begin
                push_byte(1'b1, 8'($urandom_range(0, 255)), 1'b0, NONE);
                sent++;
            end
            else if (r < 9) begin
                push_byte(1'b0, pick_byte(), 1'b0, NONE);
                sent++;
            end
            else begin
                for (k = 0; k < 4; k++)
                    push_byte(1'b0, pick_byte(), 1'b0, NONE);
                sent += 4;
            end
        end
    endtask

    // stop offering, let every due pair drain, then let the pipe go quiet
    task automatic settle();
        in_valid <= 1'b0;
        while (pairs_due.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic set_limits(input logic [11:0] ppl, input logic [11:0] lpf);
        cfg_we    <= 1'b1;
        cfg_index <= y2r_pkg::REG_PPL;
        cfg_data  <= ppl;
        @(posedge clk);
        cfg_index <= y2r_pkg::REG_LPF;
        cfg_data  <= lpf;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    // output side: random stalls, plus a long hold when asked
    initial begin : receiver
        int stall_left;
        int hold_left;
        stall_left = 0;
        hold_left  = 0;
        out_stall <= 1'b0;
        forever begin
            @(posedge clk);
            if (hold_req) begin
                hold_req  = 1'b0;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0) begin
                out_stall <= 1'b1;
                hold_left--;
            end
            else if (stall_left > 0) begin
                out_stall <= 1'b1;
                stall_left--;
            end
            else begin
                out_stall <= 1'b0;
                if (!steady && $urandom_range(0, 3) == 0)
                    stall_left = idle_len();
            end
        end
    end

    initial begin : stimulus
        int i;
        rst_n      <= 1'b0;
        cfg_we     <= 1'b0;
        cfg_index  <= y2r_pkg::REG_PPL;
        cfg_data   <= '0;
        in_valid   <= 1'b0;
        action     <= 1'b0;
        data_byte  <= '0;
        typed_on   <= 1'b0;
        typed_pair <= NONE;
        ph       = y2r_pkg::PH_Y0;
        hy0      = '0;
        hu       = '0;
        hy1      = '0;
        col_cnt  = '0;
        line_cnt = '0;
        ppl_reg  = y2r_pkg::PPL_RESET;
        lpf_reg  = y2r_pkg::LPF_RESET;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table under the reset limits
        for (i = 0; i < DIR_LEN; i++)
            push_byte(DIRECTED[i].act, DIRECTED[i].b, DIRECTED[i].typed, DIRECTED[i].want);

        // every pair ends a frame
        settle();
        set_limits(12'd1, 12'd1);
        run_random(200, 1'b1);

        // zero limits act as one
        settle();
        set_limits(12'd0, 12'd0);
        run_random(150, 1'b1);

        // small frame; output held off while bytes keep coming
        settle();
        set_limits(12'd3, 12'd2);
        steady   = 1'b1;
        hold_req = 1'b1;
        run_random(80, 1'b0);
        steady = 1'b0;
        run_random(150, 1'b1);

        // build up position, then lower both limits under it
        settle();
        set_limits(12'd7, 12'd5);
        run_random(170, 1'b0);
        settle();
        set_limits(12'd2, 12'd1);
        run_random(150, 1'b1);

        settle();
        set_limits(12'd2048, 12'd3);
        run_random(150, 1'b1);

        settle();
        set_limits(y2r_pkg::PPL_RESET, y2r_pkg::LPF_RESET);
        run_random(150, 1'b1);

        settle();
        repeat (20) @(posedge clk);
        if (pairs_due.size() != 0)
            flag_mismatch("pairs still due", pairs_due.size(), 0);
        if (errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // watchdog
    initial begin : watchdog
        #(30_000_000);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

>>> filelist.f
sv/y2r_pkg.sv
sv/y2r_front.sv
sv/y2r_queue.sv
sv/y2r_back.sv
sv/yuyv_to_rgb888_stream_core.sv
sim/tb.sv
